### src/assert_macros.svh
// Assertion macros shared by the refresher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold on every clock edge outside reset.
`define DBR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent on one edge requires the consequent on the next edge.
`define DBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DBR_ASSERT_ALWAYS(lbl, cond)
`define DBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/dbr_pkg.sv
// Types, constants and state encoding for the dirty-byte refresher.
package dbr_pkg;

  // Panel geometry
  localparam int PAGE_COUNT   = 8;
  localparam int COLUMN_COUNT = 128;
  localparam int FRAME_BYTES  = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W        = $clog2(COLUMN_COUNT);

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Panel command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  // Position of a byte within one four-byte update
  typedef enum logic [1:0] {
    SLOT_PAGE   = 2'd0,
    SLOT_COL_HI = 2'd1,
    SLOT_COL_LO = 2'd2,
    SLOT_DATA   = 2'd3
  } byte_slot_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SEND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;      // clearing pass, one entry per cycle
    logic accept;     // input transaction taken this cycle
    logic look;       // compare registered work/shadow bytes
    logic next_byte;  // output transaction taken this cycle
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic tick_go;
    logic differ;
    logic byte_last;
  } ctl_stat_t;

endpackage

### src/dbr_ctrl.sv
// Controller state machine for the dirty-byte refresher.
module dbr_ctrl import dbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && stat.tick_go) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = stat.differ ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        out_valid     = 1'b1;
        cmd.next_byte = !out_stall;
        if (!out_stall && stat.byte_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/dbr_datapath.sv
// Frame memories, scan registers and link byte formatting.
module dbr_datapath import dbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat,
  output out_item_t out_item
);

  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_BYTES - 1);

  logic [7:0] work_mem  [FRAME_BYTES];
  logic [7:0] shown_mem [FRAME_BYTES];

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] pos_r;
  logic              active_r;
  logic              pending_r;
  logic [7:0]        work_q_r;
  logic [7:0]        shown_q_r;
  logic [PAGE_W-1:0] page_r;
  logic [COL_W-1:0]  col_r;
  logic [7:0]        data_r;
  byte_slot_t        slot_r, slot_nxt;

  logic              in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic              start_scan;
  logic [7:0]        col_ext;

  // Write address decode
  assign in_range = (int'(in_item.page) < PAGE_COUNT) && (int'(in_item.column) < COLUMN_COUNT);
  assign wr_addr  = ADDR_W'(int'(in_item.page) * COLUMN_COUNT + int'(in_item.column));

  assign stat.tick_go    = (in_item.operation == OP_TICK) && (active_r || pending_r);
  assign stat.clear_last = (clr_cnt_r == LAST_POS);
  assign stat.differ     = (work_q_r != shown_q_r);
  assign stat.byte_last  = (slot_r == SLOT_DATA);

  assign start_scan = cmd.accept && stat.tick_go && !active_r;

  // Working frame: clearing pass or byte writes; registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      work_mem[clr_cnt_r] <= 8'h00;
    end else if (cmd.accept && in_item.operation == OP_WRITE && in_range) begin
      work_mem[wr_addr] <= in_item.pixel_byte;
    end
    if (cmd.accept) begin
      work_q_r <= work_mem[pos_r];
    end
  end

  // Shadow frame: clearing pass or update of a dirty byte; registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      shown_mem[clr_cnt_r] <= 8'h00;
    end else if (cmd.look && stat.differ) begin
      shown_mem[pos_r] <= work_q_r;
    end
    if (cmd.accept) begin
      shown_q_r <= shown_mem[pos_r];
    end
  end

  // Scan control; position stays zero while no scan runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pos_r     <= '0;
      active_r  <= 1'b0;
      pending_r <= 1'b0;
      slot_r    <= SLOT_PAGE;
    end else begin
      slot_r <= slot_nxt;
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.accept && in_item.operation == OP_REQUEST) begin
        pending_r <= 1'b1;
      end else if (start_scan) begin
        pending_r <= 1'b0;
      end
      if (start_scan) begin
        active_r <= 1'b1;
      end else if (cmd.look && pos_r == LAST_POS) begin
        active_r <= 1'b0;
      end
      if (cmd.look) begin
        pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + ADDR_W'(1);
      end
    end
  end

  // Byte slot sequencing
  always_comb begin
    slot_nxt = slot_r;
    if (cmd.look) begin
      slot_nxt = SLOT_PAGE;
    end else if (cmd.next_byte) begin
      case (slot_r)
        SLOT_PAGE:   slot_nxt = SLOT_COL_HI;
        SLOT_COL_HI: slot_nxt = SLOT_COL_LO;
        SLOT_COL_LO: slot_nxt = SLOT_DATA;
        default:     slot_nxt = SLOT_PAGE;
      endcase
    end
  end

  // Capture the dirty position and its byte
  always_ff @(posedge clk) begin
    if (cmd.look && stat.differ) begin
      page_r <= PAGE_W'(pos_r / COLUMN_COUNT);
      col_r  <= COL_W'(pos_r % COLUMN_COUNT);
      data_r <= work_q_r;
    end
  end

  // Link byte formatting from held registers
  assign col_ext = 8'(col_r);

  always_comb begin
    out_item.is_data = (slot_r == SLOT_DATA);
    out_item.last    = (slot_r == SLOT_DATA);
    case (slot_r)
      SLOT_PAGE:   out_item.link_byte = CMD_PAGE_BASE + 8'(page_r);
      SLOT_COL_HI: out_item.link_byte = CMD_COL_HIGH | (8'(col_ext >> 4) & NIBBLE_MASK);
      SLOT_COL_LO: out_item.link_byte = col_ext & NIBBLE_MASK;
      default:     out_item.link_byte = data_r;
    endcase
  end

endmodule

### src/display_dirty_byte_refresher.sv
// Top level of the dirty-byte refresher: controller, datapath and checks.
// After reset the block runs a clearing pass over both 1024-byte frames, one
// entry per cycle, with in_stall high. Then a write or refresh request
// transaction is taken in idle. A scan tick, taken while a scan runs or a
// request is pending, returns to idle when the byte at the scan position
// matches the shadow (registered read of both frame memories, then the
// compare). When it is dirty, the four link bytes leave one per cycle while
// out_stall is low, from a single output slot, and the next input is taken after them.
`include "assert_macros.svh"

module display_dirty_byte_refresher import dbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  dbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dbr_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // Checks
  `DBR_ASSERT_ALWAYS(a_no_input_while_send, !(out_valid && !in_stall))
  `DBR_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.clear, cmd.accept, cmd.look, cmd.next_byte}))
  `DBR_ASSERT_NEXT(a_idle_after_last, out_valid && !out_stall && out_item.last, !out_valid)
  `DBR_ASSERT_NEXT(a_clean_no_output, cmd.look && !stat.differ, !out_valid)

endmodule
